### design/pgt_pkg.sv
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared widths, register indexes and types of the polar Gaussian transform.
// ----------------------------------------------------------------------------
package pgt_pkg;

    // Field widths.
    localparam int UNIFORM_W = 16;
    localparam int SAMPLE_W  = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_SCALE = 8'd1;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] MEAN_RESET  = 32'd0;
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 32'd65536;

    // Iteration counts of the arithmetic sections.
    localparam int LOG_ROUNDS = 28;
    localparam int DIV_STEPS  = 62;
    localparam int SQRT_STEPS = 31;

    // 2*ln(2) in Q30, rounded.
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    // One finished pair of samples leaving the pipeline.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
    } pgt_result_t;

endpackage

### design/pgt_pipe.sv
// ----------------------------------------------------------------------------
// pgt_pipe
// Fully pipelined datapath: squares, rejection, log2 by repeated squaring,
// -2*ln scaling, bit-serial division, digit-by-digit square root, scaling
// by the spread and saturating addition of the mean. One pair per en cycle.
// ----------------------------------------------------------------------------
module pgt_pipe (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [pgt_pkg::UNIFORM_W-1:0]    in_a,
    input  logic signed [pgt_pkg::UNIFORM_W-1:0]    in_b,
    input  logic signed [pgt_pkg::CFG_DATA_W-1:0]   mean_offset,
    input  logic        [pgt_pkg::CFG_DATA_W-1:0]   spread_scale,
    output pgt_pkg::pgt_result_t                    result
);

    localparam int LR = pgt_pkg::LOG_ROUNDS;
    localparam int DS = pgt_pkg::DIV_STEPS;
    localparam int SS = pgt_pkg::SQRT_STEPS;

    // Index of the top set bit of a nonzero 30-bit value.
    function automatic logic [4:0] top_bit(input logic [29:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 30; i++) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // ------------------------------------------------------------------
    // Stage 0: register the squares and signs.
    // ------------------------------------------------------------------
    logic        v0_reg;
    logic [1:0]  neg0_reg;
    logic [30:0] sqa0_reg, sqb0_reg;
    logic signed [31:0] prod_a, prod_b;

    assign prod_a = in_a * in_a;
    assign prod_b = in_b * in_b;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg <= {in_b[pgt_pkg::UNIFORM_W-1], in_a[pgt_pkg::UNIFORM_W-1]};
            sqa0_reg <= prod_a[30:0];
            sqb0_reg <= prod_b[30:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sum of squares; reject zero and points outside the open unit disk.
    // ------------------------------------------------------------------
    logic        v1_reg;
    logic [1:0]  neg1_reg;
    logic [29:0] r1_reg, va1_reg, vb1_reg;
    logic [31:0] rsum;

    assign rsum = {1'b0, sqa0_reg} + {1'b0, sqb0_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= neg0_reg;
            r1_reg   <= rsum[29:0];
            va1_reg  <= sqa0_reg[29:0];
            vb1_reg  <= sqb0_reg[29:0];
        end
    end

    // ------------------------------------------------------------------
    // Log2 section. Entry 0 is the normalized mantissa; each later entry
    // squares it once and yields one fraction bit.
    // ------------------------------------------------------------------
    logic        lg_v_reg   [0:LR];
    logic [30:0] lg_m_reg   [0:LR];
    logic [27:0] lg_g_reg   [0:LR];
    logic [4:0]  lg_k_reg   [0:LR];
    logic [29:0] lg_r_reg   [0:LR];
    logic [29:0] lg_va_reg  [0:LR];
    logic [29:0] lg_vb_reg  [0:LR];
    logic [1:0]  lg_neg_reg [0:LR];

    logic [4:0]  norm_shift;
    logic [30:0] norm_m;

    assign norm_shift = 5'd30 - top_bit(r1_reg);
    assign norm_m     = {1'b0, r1_reg} << norm_shift;

    always_ff @(posedge aclk) begin
        if (en) begin
            lg_m_reg[0]   <= norm_m;
            lg_g_reg[0]   <= '0;
            lg_k_reg[0]   <= norm_shift;
            lg_r_reg[0]   <= r1_reg;
            lg_va_reg[0]  <= va1_reg;
            lg_vb_reg[0]  <= vb1_reg;
            lg_neg_reg[0] <= neg1_reg;
        end
    end

    for (genvar j = 0; j < LR; j++) begin : g_log
        logic [61:0] sq;
        logic [31:0] t;
        assign sq = {31'd0, lg_m_reg[j]} * {31'd0, lg_m_reg[j]};
        assign t  = sq[61:30];

        always_ff @(posedge aclk) begin
            if (en) begin
                lg_m_reg[j+1]   <= t[31] ? t[31:1] : t[30:0];
                lg_g_reg[j+1]   <= {lg_g_reg[j][26:0], t[31]};
                lg_k_reg[j+1]   <= lg_k_reg[j];
                lg_r_reg[j+1]   <= lg_r_reg[j];
                lg_va_reg[j+1]  <= lg_va_reg[j];
                lg_vb_reg[j+1]  <= lg_vb_reg[j];
                lg_neg_reg[j+1] <= lg_neg_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // W = -log2(rsq) in Q28.
    // ------------------------------------------------------------------
    logic        vw_reg;
    logic [32:0] w_reg;
    logic [29:0] rw_reg, vaw_reg, vbw_reg;
    logic [1:0]  negw_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg    <= {lg_k_reg[LR], 28'd0} - {5'd0, lg_g_reg[LR]};
            rw_reg   <= lg_r_reg[LR];
            vaw_reg  <= lg_va_reg[LR];
            vbw_reg  <= lg_vb_reg[LR];
            negw_reg <= lg_neg_reg[LR];
        end
    end

    // ------------------------------------------------------------------
    // L = -2*ln(rsq) in Q24, rounded half up.
    // ------------------------------------------------------------------
    logic        vl_reg;
    logic [29:0] l_reg, rl_reg, val_reg, vbl_reg;
    logic [1:0]  negl_reg;
    logic [64:0] lprod;

    assign lprod = ({32'd0, w_reg} * {34'd0, pgt_pkg::TWO_LN2_Q30}) + (65'd1 << 33);

    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg    <= lprod[63:34];
            rl_reg   <= rw_reg;
            val_reg  <= vaw_reg;
            vbl_reg  <= vbw_reg;
            negl_reg <= negw_reg;
        end
    end

    // ------------------------------------------------------------------
    // Division section: Z = floor(V*V*L * 2^32 / R), one quotient bit per
    // stage. The numerator bits still to go and the quotient share a shift
    // register. Entry 0 holds the loaded numerator.
    // ------------------------------------------------------------------
    logic        dv_v_reg    [0:DS];
    logic [29:0] dv_r_reg    [0:DS];
    logic [1:0]  dv_neg_reg  [0:DS];
    logic [29:0] dv_rema_reg [0:DS];
    logic [61:0] dv_nqa_reg  [0:DS];
    logic [29:0] dv_remb_reg [0:DS];
    logic [61:0] dv_nqb_reg  [0:DS];

    logic [59:0] pa, pb;

    assign pa = {30'd0, val_reg} * {30'd0, l_reg};
    assign pb = {30'd0, vbl_reg} * {30'd0, l_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_r_reg[0]    <= rl_reg;
            dv_neg_reg[0]  <= negl_reg;
            dv_rema_reg[0] <= pa[59:30];
            dv_nqa_reg[0]  <= {pa[29:0], 32'd0};
            dv_remb_reg[0] <= pb[59:30];
            dv_nqb_reg[0]  <= {pb[29:0], 32'd0};
        end
    end

    for (genvar j = 0; j < DS; j++) begin : g_div
        logic [30:0] ta, tb;
        logic        qa, qb;
        logic [30:0] da, db;
        assign ta = {dv_rema_reg[j], dv_nqa_reg[j][61]};
        assign tb = {dv_remb_reg[j], dv_nqb_reg[j][61]};
        assign qa = ta >= {1'b0, dv_r_reg[j]};
        assign qb = tb >= {1'b0, dv_r_reg[j]};
        assign da = ta - {1'b0, dv_r_reg[j]};
        assign db = tb - {1'b0, dv_r_reg[j]};

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_r_reg[j+1]    <= dv_r_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_rema_reg[j+1] <= qa ? da[29:0] : ta[29:0];
                dv_nqa_reg[j+1]  <= {dv_nqa_reg[j][60:0], qa};
                dv_remb_reg[j+1] <= qb ? db[29:0] : tb[29:0];
                dv_nqb_reg[j+1]  <= {dv_nqb_reg[j][60:0], qb};
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root section: T = floor(sqrt(Z)), one root bit per stage.
    // Entry 0 takes the quotient with an empty remainder and root.
    // ------------------------------------------------------------------
    logic        sq_v_reg    [0:SS];
    logic [1:0]  sq_neg_reg  [0:SS];
    logic [31:0] sq_rema_reg [0:SS];
    logic [30:0] sq_rta_reg  [0:SS];
    logic [61:0] sq_za_reg   [0:SS];
    logic [31:0] sq_remb_reg [0:SS];
    logic [30:0] sq_rtb_reg  [0:SS];
    logic [61:0] sq_zb_reg   [0:SS];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_neg_reg[0]  <= dv_neg_reg[DS];
            sq_rema_reg[0] <= '0;
            sq_rta_reg[0]  <= '0;
            sq_za_reg[0]   <= dv_nqa_reg[DS];
            sq_remb_reg[0] <= '0;
            sq_rtb_reg[0]  <= '0;
            sq_zb_reg[0]   <= dv_nqb_reg[DS];
        end
    end

    for (genvar j = 0; j < SS; j++) begin : g_sqrt
        logic [33:0] ta, tb, tra, trb, da, db;
        logic        ga, gb;
        assign ta  = {sq_rema_reg[j], sq_za_reg[j][61:60]};
        assign tb  = {sq_remb_reg[j], sq_zb_reg[j][61:60]};
        assign tra = {1'b0, sq_rta_reg[j], 2'b01};
        assign trb = {1'b0, sq_rtb_reg[j], 2'b01};
        assign ga  = ta >= tra;
        assign gb  = tb >= trb;
        assign da  = ta - tra;
        assign db  = tb - trb;

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_neg_reg[j+1]  <= sq_neg_reg[j];
                sq_rema_reg[j+1] <= ga ? da[31:0] : ta[31:0];
                sq_rta_reg[j+1]  <= {sq_rta_reg[j][29:0], ga};
                sq_za_reg[j+1]   <= {sq_za_reg[j][59:0], 2'b00};
                sq_remb_reg[j+1] <= gb ? db[31:0] : tb[31:0];
                sq_rtb_reg[j+1]  <= {sq_rtb_reg[j][29:0], gb};
                sq_zb_reg[j+1]   <= {sq_zb_reg[j][59:0], 2'b00};
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale the magnitudes by the spread, rounded half up to Q16.16.
    // ------------------------------------------------------------------
    logic        vs_reg;
    logic [1:0]  negs_reg;
    logic [35:0] sa_reg, sb_reg;
    logic [63:0] spa, spb;

    assign spa = ({32'd0, spread_scale} * {33'd0, sq_rta_reg[SS]}) + (64'd1 << 27);
    assign spb = ({32'd0, spread_scale} * {33'd0, sq_rtb_reg[SS]}) + (64'd1 << 27);

    always_ff @(posedge aclk) begin
        if (en) begin
            negs_reg <= sq_neg_reg[SS];
            sa_reg   <= spa[63:28];
            sb_reg   <= spb[63:28];
        end
    end

    // ------------------------------------------------------------------
    // Add the mean with the coordinate's sign and saturate.
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] mean,
                                                   input logic [35:0] mag,
                                                   input logic neg);
        logic signed [37:0] m38, s38, sum;
        m38 = 38'(mean);
        s38 = {2'b00, mag};
        sum = neg ? (m38 - s38) : (m38 + s38);
        if (sum > 38'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (sum < -38'sd2147483648) begin
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    logic               vf_reg;
    logic signed [31:0] fa_reg, fb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            fa_reg <= sat_add(mean_offset, sa_reg, negs_reg[0]);
            fb_reg <= sat_add(mean_offset, sb_reg, negs_reg[1]);
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of every stage.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vw_reg <= 1'b0;
            vl_reg <= 1'b0;
            vs_reg <= 1'b0;
            vf_reg <= 1'b0;
            for (int i = 0; i <= LR; i++) begin
                lg_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= DS; i++) begin
                dv_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= SS; i++) begin
                sq_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg && (rsum != 32'd0) && (rsum < 32'h4000_0000);
            lg_v_reg[0] <= v1_reg;
            for (int i = 0; i < LR; i++) begin
                lg_v_reg[i+1] <= lg_v_reg[i];
            end
            vw_reg <= lg_v_reg[LR];
            vl_reg <= vw_reg;
            dv_v_reg[0] <= vl_reg;
            for (int i = 0; i < DS; i++) begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
            sq_v_reg[0] <= dv_v_reg[DS];
            for (int i = 0; i < SS; i++) begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
            vs_reg <= sq_v_reg[SS];
            vf_reg <= vs_reg;
        end
    end

    assign result.valid    = vf_reg;
    assign result.sample_a = fa_reg;
    assign result.sample_b = fb_reg;

endmodule

### design/polar_gaussian_transform_unit.sv
// ----------------------------------------------------------------------------
// polar_gaussian_transform_unit
// Marsaglia polar transform of uniform pairs into pairs of normal samples.
// ----------------------------------------------------------------------------
// Each input transaction carries two signed Q1.15 uniform values. Pairs on or
// outside the unit circle, and the all-zero pair, are dropped with no output;
// every other pair gives one output transaction with two signed Q16.16
// samples, mean plus spread times the polar factor, saturated. The datapath
// takes one pair every cycle while s_tready is high; its pipeline holds the
// 28 squaring rounds of the logarithm, the 62 one-bit division steps and
// the 31 square-root steps. A two-entry output buffer keeps input
// flowing while the consumer stalls; s_tready falls only when both entries
// are full. Configuration writes are always accepted and should be made
// while no pair is in flight.
// ----------------------------------------------------------------------------
module polar_gaussian_transform_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // uniform_a, uniform_b
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,   // sample_a, sample_b
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pgt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pgt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [pgt_pkg::CFG_DATA_W-1:0] mean_offset_reg;
    logic [pgt_pkg::CFG_DATA_W-1:0] spread_scale_reg;

    logic                 en;
    pgt_pkg::pgt_result_t res;

    logic        out_valid_reg, skid_valid_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic        out_free, take;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_offset_reg  <= pgt_pkg::MEAN_RESET;
            spread_scale_reg <= pgt_pkg::SCALE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == pgt_pkg::REG_MEAN_OFFSET) begin
                mean_offset_reg <= cfg_data;
            end else if (cfg_index == pgt_pkg::REG_SPREAD_SCALE) begin
                spread_scale_reg <= cfg_data;
            end
        end
    end

    // The pipeline advances whenever the skid entry is free.
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign take     = en && res.valid;
    assign out_free = !out_valid_reg || m_tready;

    pgt_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_a         (s_tdata[15:0]),
        .in_b         (s_tdata[31:16]),
        .mean_offset  (mean_offset_reg),
        .spread_scale (spread_scale_reg),
        .result       (res)
    );

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= skid_valid_reg || take;
            end
            if (skid_valid_reg && out_free) begin
                skid_valid_reg <= 1'b0;
            end else if (take && !out_free) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : {res.sample_b, res.sample_a};
        end
        if (take && !out_free) begin
            skid_data_reg <= {res.sample_b, res.sample_a};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The skid entry is only used behind a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while the output register is empty");

    // A stalled result is never dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled output transaction was lost");

    // The skid entry fills only when the consumer stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid entry filled without a stall");

    // A write to the spread register takes effect on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == pgt_pkg::REG_SPREAD_SCALE) |=>
            (spread_scale_reg == $past(cfg_data)))
        else $error("spread register write was not applied");

endmodule
